// ----- hdl/ptt_pkg.sv -----
// Shared codes, defaults and controller/datapath handshake types for the priority task table.
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int SLOTS_DEFAULT      = 16;
   localparam int IDENT_BITS_DEFAULT = 8;

   localparam logic [7:0] PRIO_LIMIT_RESET = 8'd255;

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SELECT = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   // status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_PRESENT   = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_NONE      = 3'd4;

   typedef struct packed {
      logic load;         // latch a new command, restart the scan
      logic scan;         // walk the list, compare each entry
      logic decide;       // capture the result of the scan
      logic append;       // write new entry at end of list
      logic shift_start;  // point the walk just past the removed entry
      logic shift;        // walk the tail, moving each entry down one
      logic drop;         // shorten the list by one
      logic finish;       // move captured result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       hit;
      logic       full;
      logic       need_shift;
      logic       walk_done;
      logic       out_free;
   } ctrl_status_type;

endpackage

// ----- hdl/ptt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ptt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ptt_datapath.sv -----
// Datapath: list memory, walk counters, compare logic, result and output registers.
`timescale 1ns / 1ps

module ptt_datapath #(
   parameter int SLOTS      = ptt_pkg::SLOTS_DEFAULT,
   parameter int IDENT_BITS = ptt_pkg::IDENT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ptt_pkg::ctrl_cmd_type     cmd,
   output ptt_pkg::ctrl_status_type  status,
   input  logic [1:0]                req_tuser,
   input  logic [15:0]               req_tdata,
   input  logic                      csr_we,
   input  logic [7:0]                csr_wdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int WORD_W = IDENT_BITS + 8;

   // latched command
   logic [1:0]            op_ff;
   logic [IDENT_BITS-1:0] id_ff;
   logic [7:0]            prio_ff;
   logic [15:0]           id_wide;

   logic [7:0]            limit_ff;

   // list walk
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_pos_ff, rd_pos_in;
   logic             issue;

   // scan findings
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_pos_ff, hit_pos_in;
   logic                  best_valid_ff, best_valid_in;
   logic [IDENT_BITS-1:0] best_id_ff, best_id_in;
   logic [7:0]            best_prio_ff, best_prio_in;

   // captured result and output register
   logic [2:0]  res_status_ff, res_status_in;
   logic [7:0]  res_id_ff, res_id_in;
   logic [7:0]  res_prio_ff, res_prio_in;
   logic        res_listed_ff, res_listed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;

   // memory
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     rd_data;
   logic [IDENT_BITS-1:0] rd_id;
   logic [7:0]            rd_prio;
   logic [15:0]           best_id_wide;
   logic                  full;

   assign id_wide = {8'd0, req_tdata[7:0]};
   assign rd_id   = rd_data[IDENT_BITS-1:0];
   assign rd_prio = rd_data[WORD_W-1:IDENT_BITS];
   assign full    = (count_ff == CNT_W'(SLOTS));
   assign issue   = (cmd.scan || cmd.shift) && (ptr_ff < count_ff);

   ptt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // write port: append at the tail, or move a tail entry down during a shift
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {prio_ff, id_ff};
      if (cmd.append) begin
         wr_en = 1'b1;
      end else if (cmd.shift && rd_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_pos_ff - IDX_W'(1);
         wr_data = rd_data;
      end
   end

   always_comb begin
      ptr_in        = ptr_ff;
      rd_pend_in    = 1'b0;
      rd_pos_in     = ptr_ff[IDX_W-1:0];
      count_in      = count_ff;
      hit_in        = hit_ff;
      hit_pos_in    = hit_pos_ff;
      best_valid_in = best_valid_ff;
      best_id_in    = best_id_ff;
      best_prio_in  = best_prio_ff;

      if (cmd.load) begin
         ptr_in        = '0;
         hit_in        = 1'b0;
         best_valid_in = 1'b0;
      end
      if (cmd.shift_start) begin
         ptr_in = CNT_W'(hit_pos_ff) + CNT_W'(1);
      end
      if (issue) begin
         ptr_in     = ptr_ff + CNT_W'(1);
         rd_pend_in = 1'b1;
      end
      if (cmd.scan && rd_pend_ff) begin
         if (rd_id == id_ff && !hit_ff) begin
            hit_in     = 1'b1;
            hit_pos_in = rd_pos_ff;
         end
         // strict compare keeps the earliest entry on equal priorities
         if (rd_prio < limit_ff && (!best_valid_ff || rd_prio < best_prio_ff)) begin
            best_valid_in = 1'b1;
            best_id_in    = rd_id;
            best_prio_in  = rd_prio;
         end
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.drop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign best_id_wide = 16'(best_id_ff);

   always_comb begin
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_prio_in   = res_prio_ff;
      res_listed_in = res_listed_ff;
      if (cmd.decide) begin
         res_status_in = ptt_pkg::STATUS_OK;
         res_id_in     = 8'd0;
         res_prio_in   = 8'd0;
         res_listed_in = 1'b0;
         unique case (op_ff)
            ptt_pkg::CMD_ADD: begin
               if (hit_ff) begin
                  res_status_in = ptt_pkg::STATUS_PRESENT;
               end else if (full) begin
                  res_status_in = ptt_pkg::STATUS_FULL;
               end
            end
            ptt_pkg::CMD_REMOVE: begin
               if (!hit_ff) begin
                  res_status_in = ptt_pkg::STATUS_NOT_FOUND;
               end
            end
            ptt_pkg::CMD_SELECT: begin
               if (best_valid_ff) begin
                  res_id_in   = best_id_wide[7:0];
                  res_prio_in = best_prio_ff;
               end else begin
                  res_status_in = ptt_pkg::STATUS_NONE;
               end
            end
            ptt_pkg::CMD_QUERY: begin
               res_listed_in = hit_ff;
            end
            default: begin
               res_status_in = ptt_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ptt_pkg::PRIO_LIMIT_RESET;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tuser;
         id_ff   <= id_wide[IDENT_BITS-1:0];
         prio_ff <= req_tdata[15:8];
      end
      if (cmd.finish) begin
         rsp_data_ff <= {4'd0, res_listed_ff, res_prio_ff, res_id_ff, res_status_ff};
      end
      rd_pos_ff     <= rd_pos_in;
      hit_ff        <= hit_in;
      hit_pos_ff    <= hit_pos_in;
      best_valid_ff <= best_valid_in;
      best_id_ff    <= best_id_in;
      best_prio_ff  <= best_prio_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_prio_ff   <= res_prio_in;
      res_listed_ff <= res_listed_in;
   end

   assign status.op         = op_ff;
   assign status.hit        = hit_ff;
   assign status.full       = full;
   assign status.need_shift = (CNT_W'(hit_pos_ff) + CNT_W'(1)) < count_ff;
   assign status.walk_done  = !rd_pend_ff && (ptr_ff >= count_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/ptt_controller.sv -----
// Controller: sequences scan, update and response for one command at a time.
`timescale 1ns / 1ps

module ptt_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  ptt_pkg::ctrl_status_type status,
   output ptt_pkg::ctrl_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.walk_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_DONE;
            if (status.op == ptt_pkg::CMD_ADD && !status.hit && !status.full) begin
               cmd.append = 1'b1;
            end else if (status.op == ptt_pkg::CMD_REMOVE && status.hit) begin
               if (status.need_shift) begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  cmd.drop = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.walk_done) begin
               cmd.drop = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/priority_task_table.sv -----
// Sequence: after the transfer the whole list is scanned and the result is decided; a remove
// that has to close a gap then moves each later entry down one, and the result enters the
// output register once that register is free.
// Throughput: one command at a time; the list walk through the one-read-port RAM sets it.
// A new command is taken once the previous result sits in the output register.
// Reset (synchronous, active high) empties the list and sets the priority limit to 255.
`timescale 1ns / 1ps

module priority_task_table #(
   parameter int SLOTS      = ptt_pkg::SLOTS_DEFAULT,
   parameter int IDENT_BITS = ptt_pkg::IDENT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [15:0] req_tdata,   // task_id[7:0], task_prio[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], found_id[10:3], found_prio[18:11],
                                    // is_listed[19], zero fill
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata    // prio_limit
);

   ptt_pkg::ctrl_cmd_type    ctrl_cmd;
   ptt_pkg::ctrl_status_type ctrl_status;

   ptt_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (ctrl_status),
      .cmd        (ctrl_cmd)
   );

   ptt_datapath #(
      .SLOTS      (SLOTS),
      .IDENT_BITS (IDENT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .status     (ctrl_status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
